// ===== hw/rtl/src_pkg.sv =====
`default_nettype none

package src_pkg;

   // Chain limits.
   localparam int unsigned MAX_CLUSTERS  = 2048;
   localparam int unsigned CLUSTER_CNT_W = $clog2(MAX_CLUSTERS + 1);

   // Field widths.
   localparam int unsigned SECTOR_W = 32;
   localparam int unsigned COUNT_W  = 19;
   localparam int unsigned INDEX_W  = 8;
   localparam int unsigned CSR_W    = 8;
   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned RSP_DATA_W = 64;

   localparam logic [COUNT_W-1:0] LEN_MAX = '1;

   // Register reset values.
   localparam logic [CSR_W-1:0] CLUSTER_SECTORS_RESET = 8'd1;
   localparam logic [CSR_W-1:0] ENTRY_LIMIT_RESET     = 8'd250;

   // Register indexes on the configuration port.
   localparam logic [CSR_ADDR_W-1:0] CSR_CLUSTER_SECTORS = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ENTRY_LIMIT     = 2'd1;

   // Command queue between front and back.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // What follows the optional extent entry of a command.
   typedef enum logic [1:0] {
      TAIL_NONE  = 2'd0,
      TAIL_TERM  = 2'd1,
      TAIL_FAULT = 2'd2
   } src_tail_type;

   // One queued command: up to two result items.
   typedef struct packed {
      logic                has_entry;
      logic [INDEX_W-1:0]  entry_index;
      logic [SECTOR_W-1:0] first_sector;
      logic [COUNT_W-1:0]  sector_count;
      src_tail_type        tail;
      logic [INDEX_W-1:0]  term_index;
   } src_cmd_type;

endpackage

`default_nettype wire

// ===== hw/rtl/src_front.sv =====
`default_nettype none

module src_front (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [src_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [src_pkg::CSR_W-1:0]         csr_wdata,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [src_pkg::SECTOR_W-1:0]      req_sector,
   input  wire logic                              req_end,
   input  wire logic                              queue_full,
   output logic                                   push,
   output src_pkg::src_cmd_type                   cmd
);

   logic [src_pkg::CSR_W-1:0]         cluster_sectors_ff;
   logic [src_pkg::CSR_W-1:0]         entry_limit_ff;
   logic [src_pkg::SECTOR_W-1:0]      run_start_ff, run_start_in;
   logic [src_pkg::SECTOR_W-1:0]      run_expected_ff, run_expected_in;
   logic [src_pkg::COUNT_W-1:0]       run_length_ff, run_length_in;
   logic [src_pkg::INDEX_W-1:0]       entries_made_ff, entries_made_in;
   logic [src_pkg::CLUSTER_CNT_W-1:0] clusters_seen_ff, clusters_seen_in;
   logic                              aborted_ff, aborted_in;
   logic                              accept;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && !queue_full;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cluster_sectors_ff <= src_pkg::CLUSTER_SECTORS_RESET;
         entry_limit_ff     <= src_pkg::ENTRY_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            src_pkg::CSR_CLUSTER_SECTORS: cluster_sectors_ff <= csr_wdata;
            src_pkg::CSR_ENTRY_LIMIT:     entry_limit_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Classify the item and work out the next chain state and the command.
   always_comb begin
      logic                            is_end;
      logic                            run_open;
      logic [src_pkg::INDEX_W:0]       next_index;
      logic [src_pkg::COUNT_W:0]       len_sum;
      logic                            over;

      is_end     = req_end || (req_sector == '0);
      run_open   = (run_length_ff != '0);
      next_index = {1'b0, entries_made_ff} + 1'b1;
      len_sum    = {1'b0, run_length_ff} + {{(src_pkg::COUNT_W+1-src_pkg::CSR_W){1'b0}},
                                            cluster_sectors_ff};
      over       = next_index > {1'b0, entry_limit_ff};

      run_start_in     = run_start_ff;
      run_expected_in  = run_expected_ff;
      run_length_in    = run_length_ff;
      entries_made_in  = entries_made_ff;
      clusters_seen_in = clusters_seen_ff;
      aborted_in       = aborted_ff;

      cmd.has_entry    = 1'b0;
      cmd.entry_index  = entries_made_ff;
      cmd.first_sector = run_start_ff;
      cmd.sector_count = run_length_ff;
      cmd.tail         = src_pkg::TAIL_NONE;
      cmd.term_index   = entries_made_ff;

      if (is_end) begin
         // End of chain: flush the open run and terminate, or report the abort.
         if (aborted_ff) begin
            cmd.tail = src_pkg::TAIL_FAULT;
         end else begin
            cmd.has_entry = run_open;
            cmd.tail      = src_pkg::TAIL_TERM;
            if (run_open) begin
               cmd.term_index = next_index[src_pkg::INDEX_W] ? '1
                                                             : next_index[src_pkg::INDEX_W-1:0];
            end
         end
         run_start_in     = '0;
         run_expected_in  = '0;
         run_length_in    = '0;
         entries_made_in  = '0;
         clusters_seen_in = '0;
         aborted_in       = 1'b0;
      end else if (!aborted_ff &&
                   clusters_seen_ff < src_pkg::CLUSTER_CNT_W'(src_pkg::MAX_CLUSTERS)) begin
         clusters_seen_in = clusters_seen_ff + 1'b1;
         if (cluster_sectors_ff == '0) begin
            // A zero cluster size cannot form a run.
            aborted_in = 1'b1;
            cmd.tail   = src_pkg::TAIL_FAULT;
         end else if (run_open && req_sector == run_expected_ff) begin
            // The cluster continues the run.
            run_length_in   = len_sum[src_pkg::COUNT_W] ? src_pkg::LEN_MAX
                                                        : len_sum[src_pkg::COUNT_W-1:0];
            run_expected_in = run_expected_ff +
                              {{(src_pkg::SECTOR_W-src_pkg::CSR_W){1'b0}}, cluster_sectors_ff};
         end else if (run_open && over) begin
            // Closing this run would pass the entry limit.
            cmd.has_entry = 1'b1;
            cmd.tail      = src_pkg::TAIL_FAULT;
            aborted_in    = 1'b1;
         end else begin
            // Close the open run, if any, and start a new one here.
            cmd.has_entry   = run_open;
            if (run_open) begin
               entries_made_in = next_index[src_pkg::INDEX_W-1:0];
            end
            run_start_in    = req_sector;
            run_expected_in = req_sector +
                              {{(src_pkg::SECTOR_W-src_pkg::CSR_W){1'b0}}, cluster_sectors_ff};
            run_length_in   = {{(src_pkg::COUNT_W-src_pkg::CSR_W){1'b0}}, cluster_sectors_ff};
         end
      end

      push = accept && (cmd.has_entry || cmd.tail != src_pkg::TAIL_NONE);
   end

   // Chain state.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_start_ff     <= '0;
         run_expected_ff  <= '0;
         run_length_ff    <= '0;
         entries_made_ff  <= '0;
         clusters_seen_ff <= '0;
         aborted_ff       <= 1'b0;
      end else if (accept) begin
         run_start_ff     <= run_start_in;
         run_expected_ff  <= run_expected_in;
         run_length_ff    <= run_length_in;
         entries_made_ff  <= entries_made_in;
         clusters_seen_ff <= clusters_seen_in;
         aborted_ff       <= aborted_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/src_cmd_queue.sv =====
`default_nettype none

module src_cmd_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire src_pkg::src_cmd_type  push_cmd,
   input  wire logic                  pop,
   output logic                       head_valid,
   output src_pkg::src_cmd_type       head_cmd,
   output logic                       full
);

   src_pkg::src_cmd_type              slot_ff [src_pkg::QUEUE_DEPTH];
   logic [src_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [src_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [src_pkg::QUEUE_CNT_W-1:0]   count_ff;
   logic                              do_pop;

   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == src_pkg::QUEUE_CNT_W'(src_pkg::QUEUE_DEPTH));
   assign head_cmd   = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   function automatic logic [src_pkg::QUEUE_PTR_W-1:0] next_ptr(
      input logic [src_pkg::QUEUE_PTR_W-1:0] ptr
   );
      if (ptr == src_pkg::QUEUE_PTR_W'(src_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return ptr + 1'b1;
   endfunction

   // Storage slots.
   always_ff @(posedge clock) begin
      if (push && !full) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push && !full) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if ((push && !full) && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (!(push && !full) && do_pop) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/src_back.sv =====
`default_nettype none

module src_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          head_valid,
   input  wire src_pkg::src_cmd_type          head_cmd,
   output logic                               pop,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [src_pkg::INDEX_W-1:0]        rsp_entry_index,
   output logic [src_pkg::SECTOR_W-1:0]       rsp_first_sector,
   output logic [src_pkg::COUNT_W-1:0]        rsp_sector_count,
   output logic                               rsp_fault,
   output logic                               rsp_last
);

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        phase_ff, phase_in;
   logic [src_pkg::INDEX_W-1:0]  index_ff, index_in;
   logic [src_pkg::SECTOR_W-1:0] first_ff, first_in;
   logic [src_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic                        fault_ff, fault_in;
   logic                        last_ff, last_in;
   logic                        load;

   assign load = !rsp_valid_ff || rsp_tready;

   // Expand the head command into its result items, one per cycle while rsp_tready allows.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      phase_in     = phase_ff;
      index_in     = index_ff;
      first_in     = first_ff;
      count_in     = count_ff;
      fault_in     = fault_ff;
      last_in      = last_ff;
      pop          = 1'b0;

      if (load) begin
         rsp_valid_in = head_valid;
         if (head_valid) begin
            if (!phase_ff && head_cmd.has_entry) begin
               // The extent entry.
               index_in = head_cmd.entry_index;
               first_in = head_cmd.first_sector;
               count_in = head_cmd.sector_count;
               fault_in = 1'b0;
               last_in  = (head_cmd.tail == src_pkg::TAIL_NONE);
               if (head_cmd.tail == src_pkg::TAIL_NONE) begin
                  pop = 1'b1;
               end else begin
                  phase_in = 1'b1;
               end
            end else begin
               // The terminator or the fault that closes the command.
               first_in = '0;
               count_in = '0;
               last_in  = 1'b1;
               pop      = 1'b1;
               phase_in = 1'b0;
               case (head_cmd.tail)
                  src_pkg::TAIL_TERM: begin
                     index_in = head_cmd.term_index;
                     fault_in = 1'b0;
                  end
                  src_pkg::TAIL_FAULT: begin
                     index_in = '0;
                     fault_in = 1'b1;
                  end
                  default: begin
                     index_in = '0;
                     fault_in = 1'b0;
                  end
               endcase
            end
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
      end
   end

   // Output payload.
   always_ff @(posedge clock) begin
      index_ff <= index_in;
      first_ff <= first_in;
      count_ff <= count_in;
      fault_ff <= fault_in;
      last_ff  <= last_in;
   end

   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_entry_index  = index_ff;
   assign rsp_first_sector = first_ff;
   assign rsp_sector_count = count_ff;
   assign rsp_fault        = fault_ff;
   assign rsp_last         = last_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/sector_run_coalescer.sv =====
`default_nettype none

// Sector run coalescer. Each input item carries the first sector of the next
// cluster of a file's chain; consecutive clusters are merged into extent
// entries, which come out as result items (index, first sector, count, with
// a fault flag for a chain that is too fragmented or a zero cluster size).
// The front takes one item per clock cycle, and the back delivers one result
// item per cycle from its output register while rsp_tready allows. An item
// that closes a run and also ends the chain or hits the entry limit makes two
// result items and so holds the back for both; a four-entry command queue
// absorbs these bursts, and the input stalls only once that queue is full.
// An accepted item's command goes through the queue, then the output register.
module sector_run_coalescer (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Configuration write port.
   input  wire logic                              csr_we,
   input  wire logic [src_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [src_pkg::CSR_W-1:0]         csr_wdata,
   // Input items.
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [src_pkg::SECTOR_W-1:0]      req_tdata,  // [31:0] sector
   input  wire logic                              req_tlast,  // chain_end
   // Result items.
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [7:0] entry_index, [39:8] first_sector, [58:40] sector_count, [63:59] zero
   output logic [src_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic                                   rsp_tuser,  // fault
   output logic                                   rsp_tlast   // last
);

   src_pkg::src_cmd_type          push_cmd;
   src_pkg::src_cmd_type          head_cmd;
   logic                          push;
   logic                          pop;
   logic                          head_valid;
   logic                          queue_full;
   logic [src_pkg::INDEX_W-1:0]   rsp_entry_index;
   logic [src_pkg::SECTOR_W-1:0]  rsp_first_sector;
   logic [src_pkg::COUNT_W-1:0]   rsp_sector_count;

   src_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_sector (req_tdata),
      .req_end    (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .cmd        (push_cmd)
   );

   src_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .full       (queue_full)
   );

   src_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_cmd         (head_cmd),
      .pop              (pop),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_entry_index  (rsp_entry_index),
      .rsp_first_sector (rsp_first_sector),
      .rsp_sector_count (rsp_sector_count),
      .rsp_fault        (rsp_tuser),
      .rsp_last         (rsp_tlast)
   );

   // Pack the result fields.
   assign rsp_tdata = {{(src_pkg::RSP_DATA_W - src_pkg::INDEX_W - src_pkg::SECTOR_W
                         - src_pkg::COUNT_W){1'b0}},
                       rsp_sector_count, rsp_first_sector, rsp_entry_index};

`ifndef SYNTH
   // A fault result carries no extent and always closes its item.
   a_fault_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0 && rsp_tlast)
      else $error("fault result with nonzero fields or without last");

   // The front never pushes into a full queue.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !queue_full)
      else $error("command pushed into full queue");

   // The back pops only a command that is present.
   a_pop_needs_head: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty command queue");

   // A result that is not last is always followed by the rest of its item.
   a_not_last_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("result item sequence broken after a non-last result");
`endif

endmodule

`default_nettype wire
